FILE: rtl/core/plucked_string_synth_core_macros.svh
// ----------------------------------------------------------------------------
// Plucked string synth assertion macros
// Concurrent check wrappers; define ASSERT_OFF to compile them out.
// ----------------------------------------------------------------------------
`ifndef PLUCKED_STRING_SYNTH_CORE_MACROS_SVH
`define PLUCKED_STRING_SYNTH_CORE_MACROS_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define PSS_ASSERT_IMPLIES(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("%m: implication check failed");

// next-cycle implication
`define PSS_ASSERT_NEXT(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("%m: next-cycle check failed");

`else

`define PSS_ASSERT_IMPLIES(label, clk, rst, cond, prop)
`define PSS_ASSERT_NEXT(label, clk, rst, cond, prop)

`endif

`endif

FILE: rtl/core/pss_pkg.sv
// ----------------------------------------------------------------------------
// Plucked string synth package
// Shared widths, register codes, reset values, sequencer states and structs.
// ----------------------------------------------------------------------------
package pss_pkg;

  // default structure sizes
  localparam int RING_DEPTH_DEF = 1024;
  localparam int FRAC_BITS_DEF  = 8;

  // field widths
  localparam int NOISE_W    = 16;
  localparam int SAMPLE_W   = 16;
  localparam int PERIOD_W   = 10;
  localparam int AMP_W      = 15;
  localparam int NOTE_W     = 24;
  localparam int TAPER_W    = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  // divider sizes: |sample| * remaining count over the taper length
  localparam int DVD_W = 32;
  localparam int DVS_W = TAPER_W;
  localparam int DCNT_W = $clog2(DVD_W);

  // register reset values
  localparam logic [PERIOD_W-1:0] PERIOD_RST = PERIOD_W'(168);
  localparam logic [AMP_W-1:0]    AMP_RST    = AMP_W'(10000);
  localparam logic [NOTE_W-1:0]   NOTE_RST   = NOTE_W'(40000);
  localparam logic [TAPER_W-1:0]  TAPER_RST  = TAPER_W'(6615);

  // configuration register map
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PERIOD_LEN = 2'd0,
    REG_AMPLITUDE  = 2'd1,
    REG_NOTE_LEN   = 2'd2,
    REG_FADE_LEN   = 2'd3
  } cfg_reg_t;

  // sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_SEED,
    S_RDA,
    S_RDB,
    S_AVG,
    S_STORE,
    S_MUL,
    S_DIV,
    S_DONE
  } state_t;

  // divider status
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

FILE: rtl/core/pss_noise_if.sv
// ----------------------------------------------------------------------------
// Noise tick channel
// One beat per audio sample tick, carrying a random word.
// ----------------------------------------------------------------------------
interface pss_noise_if;
  import pss_pkg::*;

  logic               valid;
  logic               ready;
  logic [NOISE_W-1:0] noise;

  modport source (output valid, output noise, input ready);
  modport sink   (input valid, input noise, output ready);
endinterface

FILE: rtl/core/pss_sample_if.sv
// ----------------------------------------------------------------------------
// Sample output channel
// One beat per audio sample, with the end-of-note flag.
// ----------------------------------------------------------------------------
interface pss_sample_if;
  import pss_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;
  logic                       last;

  modport source (output valid, output sample, output last, input ready);
  modport sink   (input valid, input sample, input last, output ready);
endinterface

FILE: rtl/core/pss_cfg_if.sv
// ----------------------------------------------------------------------------
// Configuration write channel
// Register index plus write data, one register per beat.
// ----------------------------------------------------------------------------
interface pss_cfg_if;
  import pss_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/core/pss_ring.sv
// ----------------------------------------------------------------------------
// Delay ring memory
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module pss_ring #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10,
  parameter int DW    = 24
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/core/pss_div.sv
// ----------------------------------------------------------------------------
// Taper divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pss_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [pss_pkg::DVD_W-1:0] dividend,
  input  logic [pss_pkg::DVS_W-1:0] divisor,
  output logic [pss_pkg::SAMPLE_W-1:0] quotient,
  output pss_pkg::div_stat_t        stat
);
  import pss_pkg::*;

  logic [DVD_W-1:0]  acc;
  logic [DVS_W-1:0]  rem;
  logic [DCNT_W-1:0] cnt;
  logic              busy;
  logic              done;

  logic [DVS_W:0]    rem_sh;
  logic              fits;
  logic [DVS_W:0]    rem_sub;

  // one shift-compare-subtract step
  always_comb begin
    rem_sh  = {rem, acc[DVD_W-1]};
    fits    = rem_sh >= {1'b0, divisor};
    rem_sub = rem_sh - {1'b0, divisor};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + DCNT_W'(1);
        if (cnt == DCNT_W'(DVD_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath: dividend shifts out as quotient bits shift in
  always_ff @(posedge clk) begin
    if (start) begin
      acc <= dividend;
      rem <= '0;
    end else if (busy) begin
      acc <= {acc[DVD_W-2:0], fits};
      rem <= fits ? rem_sub[DVS_W-1:0] : rem_sh[DVS_W-1:0];
    end
  end

  // quotient never exceeds the sample magnitude
  assign quotient  = acc[SAMPLE_W-1:0];
  assign stat.busy = busy;
  assign stat.done = done;

endmodule

FILE: rtl/core/plucked_string_synth_core.sv
// ----------------------------------------------------------------------------
// Plucked string synth core
// Karplus-Strong voice: noise-seeded delay ring, two-tap averaging, end fade.
// ----------------------------------------------------------------------------
// Each noise beat yields one sample beat. The first effective delay length
// plus one ticks of a note load the ring with scaled noise; later ticks read
// two ring entries one after the other through the single read port and
// store their floored mean. In the final fade-length samples of a note a
// multiply state and the bit-serial divider follow the store. The next noise
// beat is taken while a finished sample still waits on the output.
// Configuration writes are accepted every cycle outside reset but should only
// be issued when no sample is in flight. The ring is not cleared after reset.
module plucked_string_synth_core #(
  parameter int RING_DEPTH = pss_pkg::RING_DEPTH_DEF,
  parameter int FRAC_BITS  = pss_pkg::FRAC_BITS_DEF
) (
  input logic                clk,
  input logic                rst,
  pss_cfg_if.sink            cfg,
  pss_noise_if.sink          noise_stream,
  pss_sample_if.source       sample_stream
);
  import pss_pkg::*;

  localparam int PW = $clog2(RING_DEPTH);
  localparam int RW = SAMPLE_W + FRAC_BITS;
  localparam int SPW = SAMPLE_W + AMP_W + 2;
  localparam logic [RW-1:0] FRAC_MASK = RW'((1 << FRAC_BITS) - 1);

  // configuration registers
  logic [PERIOD_W-1:0] period_len;
  logic [AMP_W-1:0]    amplitude;
  logic [NOTE_W-1:0]   note_len;
  logic [TAPER_W-1:0]  fade_len;

  // sequencer and note state
  state_t              state, state_next;
  logic [NOTE_W-1:0]   idx;
  logic [PW-1:0]       ptr;
  logic [NOISE_W-1:0]  noise_q;

  // datapath registers
  logic signed [RW-1:0]       a_q;
  logic signed [RW-1:0]       stored;
  logic [SAMPLE_W-1:0]        s_mag;
  logic                       s_neg;
  logic [TAPER_W-1:0]         rem_q;
  logic                       last_q;
  logic signed [SAMPLE_W-1:0] res_q;

  // output register
  logic                       out_valid;
  logic signed [SAMPLE_W-1:0] out_sample;
  logic                       out_last;

  // combinational
  logic [PERIOD_W-1:0]        period_eff;
  logic [PW-1:0]              len;
  logic                       seeding;
  logic [PW-1:0]              addr_a, addr_b, raddr;
  logic [RW-1:0]              ring_rdata;
  logic signed [SAMPLE_W:0]   seed_factor;
  logic signed [AMP_W:0]      amp_s;
  logic signed [SPW-1:0]      seed_prod;
  logic signed [RW:0]         pair_sum;
  logic                       rnd_up;
  logic signed [SAMPLE_W-1:0] s_val;
  logic [NOTE_W-1:0]          n_eff;
  logic                       last_c;
  logic [NOTE_W-1:0]          rem_c;
  logic                       taper_c;
  logic                       in_acc;
  logic                       out_load;
  logic [DVD_W-1:0]           mul_prod;
  logic [SAMPLE_W-1:0]        div_q;
  div_stat_t                  div_st;

  // slot k entries behind the write pointer, modulo the ring depth
  function automatic logic [PW-1:0] slot_back(input logic [PW-1:0] p,
                                              input logic [PW:0]   k);
    logic [PW:0] diff;
    diff = {1'b0, p} - k;
    if (diff[PW]) begin
      diff = diff + (PW+1)'(RING_DEPTH);
    end
    return diff[PW-1:0];
  endfunction

  // configuration writes
  assign cfg.ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      period_len <= PERIOD_RST;
      amplitude  <= AMP_RST;
      note_len   <= NOTE_RST;
      fade_len   <= TAPER_RST;
    end else if (cfg.valid) begin
      unique case (cfg_reg_t'(cfg.index))
        REG_PERIOD_LEN: period_len <= cfg.data[PERIOD_W-1:0];
        REG_AMPLITUDE:  amplitude  <= cfg.data[AMP_W-1:0];
        REG_NOTE_LEN:   note_len   <= cfg.data[NOTE_W-1:0];
        REG_FADE_LEN:   fade_len   <= cfg.data[TAPER_W-1:0];
      endcase
    end
  end

  // effective delay length: zero acts as one, clamp below the ring depth
  always_comb begin
    period_eff = (period_len == '0) ? PERIOD_W'(1) : period_len;
    if (32'(period_eff) > RING_DEPTH - 1) begin
      len = PW'(RING_DEPTH - 1);
    end else begin
      len = PW'(period_eff);
    end
    seeding = idx <= NOTE_W'(len);
    addr_a  = slot_back(ptr, {1'b0, len});
    addr_b  = slot_back(ptr, {1'b0, len} + (PW+1)'(1));
    raddr   = (state == S_RDA) ? addr_a : addr_b;
  end

  pss_ring #(
    .DEPTH (RING_DEPTH),
    .AW    (PW),
    .DW    (RW)
  ) u_ring (
    .clk   (clk),
    .we    (state == S_STORE),
    .waddr (ptr),
    .wdata (stored),
    .raddr (raddr),
    .rdata (ring_rdata)
  );

  // seed: (2*noise - 65536) * amp, floored into Q.FRAC_BITS
  always_comb begin
    seed_factor = $signed({~noise_q[NOISE_W-1], noise_q[NOISE_W-2:0], 1'b0});
    amp_s       = $signed({1'b0, amplitude});
    seed_prod   = SPW'(seed_factor) * SPW'(amp_s);
    pair_sum    = $signed({a_q[RW-1], a_q}) + $signed({ring_rdata[RW-1], ring_rdata});
  end

  // sample: truncate toward zero, then fade bookkeeping
  always_comb begin
    rnd_up  = stored[RW-1] && ((stored & FRAC_MASK) != '0);
    s_val   = SAMPLE_W'(stored >>> FRAC_BITS) + $signed({{(SAMPLE_W-1){1'b0}}, rnd_up});
    n_eff   = (note_len == '0) ? NOTE_W'(1) : note_len;
    last_c  = idx >= n_eff - NOTE_W'(1);
    rem_c   = (idx < n_eff) ? n_eff - idx : NOTE_W'(1);
    taper_c = (fade_len != '0) && (rem_c <= NOTE_W'(fade_len));
    mul_prod = DVD_W'(s_mag) * DVD_W'(rem_q);
  end

  pss_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (state == S_MUL),
    .dividend (mul_prod),
    .divisor  (fade_len),
    .quotient (div_q),
    .stat     (div_st)
  );

  // handshakes
  assign noise_stream.ready = (state == S_IDLE) && !rst;
  assign in_acc   = noise_stream.valid && noise_stream.ready;
  assign out_load = (state == S_DONE) && (!out_valid || sample_stream.ready);

  // sequencer state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (in_acc) state_next = seeding ? S_SEED : S_RDA;
      S_SEED:  state_next = S_STORE;
      S_RDA:   state_next = S_RDB;
      S_RDB:   state_next = S_AVG;
      S_AVG:   state_next = S_STORE;
      S_STORE: state_next = taper_c ? S_MUL : S_DONE;
      S_MUL:   state_next = S_DIV;
      S_DIV:   if (div_st.done) state_next = S_DONE;
      S_DONE:  if (out_load) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // note index and write pointer advance once per sample
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
      ptr <= '0;
    end else if (state == S_STORE) begin
      idx <= last_c ? '0 : idx + NOTE_W'(1);
      ptr <= (ptr == PW'(RING_DEPTH - 1)) ? '0 : ptr + PW'(1);
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      noise_q <= noise_stream.noise;
    end
    if (state == S_RDB) begin
      a_q <= ring_rdata;
    end
    if (state == S_SEED) begin
      stored <= RW'(seed_prod >>> (16 - FRAC_BITS));
    end else if (state == S_AVG) begin
      stored <= pair_sum[RW:1];
    end
    if (state == S_STORE) begin
      s_neg  <= s_val[SAMPLE_W-1];
      s_mag  <= s_val[SAMPLE_W-1] ? SAMPLE_W'(-s_val) : SAMPLE_W'(s_val);
      rem_q  <= rem_c[TAPER_W-1:0];
      last_q <= last_c;
      res_q  <= s_val;
    end else if (state == S_DIV && div_st.done) begin
      res_q <= s_neg ? $signed(-div_q) : $signed(div_q);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (sample_stream.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_sample <= res_q;
      out_last   <= last_q;
    end
  end

  assign sample_stream.valid  = out_valid;
  assign sample_stream.sample = out_sample;
  assign sample_stream.last   = out_last;

  // checks
`include "plucked_string_synth_core_macros.svh"

  `PSS_ASSERT_NEXT(a_busy_after_beat, clk, rst, in_acc, !noise_stream.ready)
  `PSS_ASSERT_IMPLIES(a_div_done_in_div, clk, rst, div_st.done, state == S_DIV)
  `PSS_ASSERT_NEXT(a_ptr_advances, clk, rst, state == S_STORE, ptr != $past(ptr))
  `PSS_ASSERT_IMPLIES(a_div_idle_start, clk, rst, state == S_MUL, !div_st.busy)

endmodule

FILE: tb/pluck_checker.sv
// ----------------------------------------------------------------------------
// Plucked string synth checker
// Watches the register, noise and sample channels, runs its own copy of the
// string model on every noise beat and compares each sample beat against it.
// ----------------------------------------------------------------------------
module pluck_checker (
  input  logic  clk,
  input  logic  rst,
  pss_cfg_if    cfg,
  pss_noise_if  noise_ch,
  pss_sample_if sample_ch,
  output int    mismatches,
  output int    samples_owed,
  output int    samples_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  import pss_pkg::*;

  localparam int DEPTH = RING_DEPTH_DEF;
  localparam int FRAC  = FRAC_BITS_DEF;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last;
  } tone_beat_t;

  // shadow registers
  logic [PERIOD_W-1:0] period_r = PERIOD_RST;
  logic [AMP_W-1:0]    amp_r    = AMP_RST;
  logic [NOTE_W-1:0]   note_r   = NOTE_RST;
  logic [TAPER_W-1:0]  taper_r  = TAPER_RST;

  // string state: Q.FRAC ring, position in note, next write slot
  longint     string_ring [DEPTH];
  longint     note_pos   = 0;
  int         write_slot = 0;
  tone_beat_t samples_due [$];
  int         err_cnt    = 0;
  int         n_checked  = 0;

  initial begin
    foreach (string_ring[i]) string_ring[i] = 0;
  end

  // one audio tick of the plucked string
  function automatic tone_beat_t pluck_step(input logic [NOISE_W-1:0] w);
    longint     span, notes, prod, stored, tap_a, tap_b, level, remain;
    bit         at_end;
    tone_beat_t beat;
    span = (period_r == 0) ? 1 : longint'(period_r);
    if (span > DEPTH - 1) span = DEPTH - 1;
    notes = (note_r == 0) ? 1 : longint'(note_r);
    if (note_pos <= span) begin
      // seeding tick: noise spread over [-amp, +amp), floored
      prod   = (2 * longint'(w) - 65536) * longint'(amp_r);
      stored = (prod <<< FRAC) >>> 16;
    end else begin
      tap_a  = string_ring[(write_slot + DEPTH - span) % DEPTH];
      tap_b  = string_ring[(write_slot + DEPTH - span - 1) % DEPTH];
      stored = (tap_a + tap_b) >>> 1;
    end
    string_ring[write_slot] = stored;
    write_slot = (write_slot + 1) % DEPTH;

    // drop fraction toward zero
    level  = (stored >= 0) ? (stored >>> FRAC) : -((-stored) >>> FRAC);
    at_end = (note_pos >= notes - 1);
    if (taper_r != 0) begin
      remain = (note_pos < notes) ? notes - note_pos : 1;
      if (remain <= longint'(taper_r)) level = (level * remain) / longint'(taper_r);
    end
    note_pos = at_end ? 0 : ((note_pos + 1) & 64'hFF_FFFF);

    beat.sample = level[SAMPLE_W-1:0];
    beat.last   = at_end;
    return beat;
  endfunction

  // per-edge bookkeeping: compare, then registers, then predict
  always @(posedge clk) begin : watch
    tone_beat_t got, want;
    if (rst) begin
      period_r   = PERIOD_RST;
      amp_r      = AMP_RST;
      note_r     = NOTE_RST;
      taper_r    = TAPER_RST;
      note_pos   = 0;
      write_slot = 0;
      samples_due.delete();
    end else begin
      if (sample_ch.valid && sample_ch.ready) begin
        got.sample = sample_ch.sample;
        got.last   = sample_ch.last;
        if (samples_due.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("[%0t] unexpected sample beat: sample %0d last %0b",
                     $realtime, got.sample, got.last);
        end else begin
          want = samples_due.pop_front();
          if (got.sample !== want.sample || got.last !== want.last) begin
            err_cnt++;
            if (err_cnt <= 10)
              $display("[%0t] sample beat %0d: expected %0d last %0b, got %0d last %0b",
                       $realtime, n_checked, want.sample, want.last,
                       got.sample, got.last);
          end
          n_checked++;
        end
      end

      if (cfg.valid && cfg.ready) begin
        case (cfg_reg_t'(cfg.index))
          REG_PERIOD_LEN: period_r = cfg.data[PERIOD_W-1:0];
          REG_AMPLITUDE:  amp_r    = cfg.data[AMP_W-1:0];
          REG_NOTE_LEN:   note_r   = cfg.data[NOTE_W-1:0];
          REG_FADE_LEN:   taper_r  = cfg.data[TAPER_W-1:0];
          default: ;
        endcase
      end

      if (noise_ch.valid && noise_ch.ready)
        samples_due.push_back(pluck_step(noise_ch.noise));
    end
    samples_owed    <= samples_due.size();
    mismatches      <= err_cnt;
    samples_checked <= n_checked;
  end

endmodule

FILE: tb/tb_plucked_string_synth_core.sv
// ----------------------------------------------------------------------------
// Plucked string synth core testbench
// Directed corner notes, then random register settings with random noise
// beats and random stalls on both channels; a side checker predicts every
// sample, and this top drives stimulus and reports the outcome.
// ----------------------------------------------------------------------------
module tb_plucked_string_synth_core;
  timeunit 1ns;
  timeprecision 1ps;

  import pss_pkg::*;

  localparam int STALL_LIMIT = 4000;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN       = 60;
  localparam int BEAT_TARGET = 780;

  logic clk;
  logic rst;

  pss_cfg_if    cfg_bus ();
  pss_noise_if  noise_bus ();
  pss_sample_if sample_bus ();

  int mismatches, samples_owed, samples_checked;

  bit hold_now    = 1'b0;
  bit hold_served = 1'b0;
  bit rx_steady   = 1'b0;
  bit tx_steady   = 1'b0;
  int beats_sent  = 0;
  int writes_done = 0;
  int settings_used = 0;

  plucked_string_synth_core DUT (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg_bus),
    .noise_stream  (noise_bus),
    .sample_stream (sample_bus)
  );

  pluck_checker u_checker (
    .clk             (clk),
    .rst             (rst),
    .cfg             (cfg_bus),
    .noise_ch        (noise_bus),
    .sample_ch       (sample_bus),
    .mismatches      (mismatches),
    .samples_owed    (samples_owed),
    .samples_checked (samples_checked)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // mostly no gap, some short, a few long
  function automatic int gap_len();
    int r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(3, 1);
    return $urandom_range(60, 10);
  endfunction

  // one register beat; valid stays up for a following write
  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= val;
    do @(posedge clk); while (!cfg_bus.ready);
    writes_done++;
  endtask

  task automatic set_config(input logic [CFG_DATA_W-1:0] per, amp, nlen, tap);
    write_reg(REG_PERIOD_LEN, per);
    write_reg(REG_AMPLITUDE, amp);
    write_reg(REG_NOTE_LEN, nlen);
    write_reg(REG_FADE_LEN, tap);
    cfg_bus.valid <= 1'b0;
    settings_used++;
  endtask

  // noise beat with an optional leading gap
  task automatic send_noise(input logic [NOISE_W-1:0] w);
    int g;
    g = tx_steady ? 0 : gap_len();
    if (g > 0) begin
      noise_bus.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    noise_bus.valid <= 1'b1;
    noise_bus.noise <= w;
    do @(posedge clk); while (!noise_bus.ready);
    beats_sent++;
  endtask

  // stop offering and wait for every predicted sample
  task automatic wait_idle();
    noise_bus.valid <= 1'b0;
    do @(posedge clk); while (samples_owed != 0);
  endtask

  task automatic send_list(input logic [NOISE_W-1:0] words [$]);
    foreach (words[i]) send_noise(words[i]);
    wait_idle();
  endtask

  // random register setting followed by a burst of noise beats
  task automatic random_phase(input bit pressure);
    int r, items, per, nlen, tap, amp, cap;
    logic [CFG_DATA_W-1:0] pd, ad, nd, td;
    r = $urandom_range(19);
    if (r < 13)      per = $urandom_range(40, 1);
    else if (r < 15) per = 0;
    else if (r < 16) per = 1023;
    else             per = $urandom_range(1022, 41);

    r = $urandom_range(9);
    if (r == 0)      amp = 0;
    else if (r == 1) amp = 32767;
    else             amp = $urandom_range(32767);

    r = $urandom_range(19);
    if (r < 13)       nlen = per + $urandom_range(150, 1);
    else if (r == 13) nlen = 0;
    else if (r == 14) nlen = 1;
    else if (r == 15) nlen = 24'hFF_FFFF;
    else              nlen = $urandom_range(24'hFF_FFFF);

    cap = (nlen > 65535) ? 65535 : nlen;
    r = $urandom_range(9);
    if (r < 2)      tap = 0;
    else if (r < 5) tap = cap;
    else if (r == 5) tap = 65535;
    else if (r < 8) tap = $urandom_range(cap);
    else            tap = $urandom_range(65535);

    pd = CFG_DATA_W'(per);
    ad = CFG_DATA_W'(amp);
    nd = CFG_DATA_W'(nlen);
    td = CFG_DATA_W'(tap);
    // junk above the register width must be ignored
    if ($urandom_range(3) == 0) begin
      pd = CFG_DATA_W'($urandom());
      pd[PERIOD_W-1:0] = PERIOD_W'(per);
      ad = CFG_DATA_W'($urandom());
      ad[AMP_W-1:0] = AMP_W'(amp);
      td = CFG_DATA_W'($urandom());
      td[TAPER_W-1:0] = TAPER_W'(tap);
    end
    set_config(pd, ad, nd, td);

    items     = pressure ? 60 : $urandom_range(60, 15);
    tx_steady = pressure || ($urandom_range(4) == 0);
    rx_steady = ($urandom_range(4) == 0);
    if (pressure) hold_now = 1'b1;
    repeat (items) begin
      r = $urandom_range(19);
      if (r == 0)      send_noise('0);
      else if (r == 1) send_noise('1);
      else             send_noise(NOISE_W'($urandom_range(65535)));
    end
    wait_idle();
  endtask

  // sample receiver with random stalls and one long hold-off
  initial begin : sample_sink
    int  gap;
    bit  take;
    gap = 0;
    sample_bus.ready = 1'b0;
    forever begin
      @(posedge clk);
      take = sample_bus.valid && sample_bus.ready;
      if (take) gap = rx_steady ? 0 : gap_len();
      if (hold_now && !hold_served) begin
        sample_bus.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_served = 1'b1;
        gap = 0;
      end else if (gap > 0) begin
        sample_bus.ready <= 1'b0;
        gap--;
      end else begin
        sample_bus.ready <= 1'b1;
      end
    end
  end

  // quiet-cycle watchdog
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((cfg_bus.valid && cfg_bus.ready) || (noise_bus.valid && noise_bus.ready) ||
          (sample_bus.valid && sample_bus.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("plucked_string_synth_core verification failed");
    $finish;
  end

  // stimulus and verdict
  initial begin : stimulus
    logic [NOISE_W-1:0] words [$];
    rst             = 1'b1;
    cfg_bus.valid   = 1'b0;
    cfg_bus.index   = REG_PERIOD_LEN;
    cfg_bus.data    = '0;
    noise_bus.valid = 1'b0;
    noise_bus.noise = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // zero period and zero note length: every tick seeds and is last
    set_config(24'd0, 24'd32767, 24'd0, 24'd0);
    words = {16'h0000, 16'hFFFF, 16'h8000, 16'h0001, 16'h7FFF};
    send_list(words);

    // shortest period, short note, widest taper: averaging and note wrap
    set_config(24'd1, 24'd32767, 24'd8, 24'd65535);
    words = {16'h0000, 16'hFFFF};
    repeat (8) words.push_back(NOISE_W'($urandom_range(65535)));
    send_list(words);

    // longest period and note, then note cut below the running index
    set_config(24'd1023, 24'd32767, 24'hFF_FFFF, 24'd3);
    words = {16'hFFFF, 16'h0000, 16'h1234, 16'hEDCB};
    send_list(words);
    set_config(24'd1023, 24'd32767, 24'd2, 24'd3);
    words = {16'hFFFF, 16'h0000};
    send_list(words);

    // zero amplitude: silent seeds and averages
    set_config(24'd2, 24'd0, 24'd5, 24'd5);
    words = {16'hFFFF, 16'h0000, 16'hA5A5, 16'h5A5A, 16'hFFFF, 16'h0000};
    send_list(words);

    // random part; the first phase carries the long receiver hold-off
    random_phase(1'b1);
    while (beats_sent < BEAT_TARGET) random_phase(1'b0);

    wait_idle();
    repeat (DRAIN) @(posedge clk);

    $display("Covered %0d noise beats and %0d checked samples over %0d register settings",
             beats_sent, samples_checked, settings_used);
    $display("(%0d register writes, %0d mismatches)", writes_done, mismatches);
    if (mismatches == 0 && samples_owed == 0) begin
      $display("plucked_string_synth_core verification clean");
    end else begin
      $display("plucked_string_synth_core verification failed");
    end
    $finish;
  end

endmodule
